// File: src/sde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sde_pkg;

  // Operation codes of an input request.
  localparam logic [1:0] OP_SPIKE     = 2'd0;
  localparam logic [1:0] OP_ATTRIBUTE = 2'd1;
  localparam logic [1:0] OP_GROUP_END = 2'd2;
  localparam logic [1:0] OP_TERMINATE = 2'd3;

  // Status codes of a result word.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ORDER    = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  // Field and state widths.
  localparam int NEURON_W = 24;
  localparam int SLICE_W  = 3;
  localparam int GSIZE_W  = 25;
  localparam int POS_W    = 27;
  localparam int CARRY_W  = 37;
  localparam int DELTA_W  = 38;
  localparam int OUT_W    = 32;

  // Most words one delta may expand into.
  localparam int MAX_WORDS = 33;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // One command for the back: either a delta to split into escape words,
  // or one word to send as it is.
  typedef struct packed {
    logic                 is_delta;
    logic [DELTA_W-1:0]   value;
    logic [1:0]           status;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/sde_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sde_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [sde_pkg::NEURON_W-1:0]  neuron_index;
  logic [sde_pkg::SLICE_W-1:0]   slice_index;
  logic [sde_pkg::GSIZE_W-1:0]   group_size;
  logic [31:0]                   attribute_word;

  modport source (output valid, output operation, output neuron_index, output slice_index,
                  output group_size, output attribute_word, input ready);
  modport sink (input valid, input operation, input neuron_index, input slice_index,
                input group_size, input attribute_word, output ready);
endinterface

`default_nettype wire

// File: src/sde_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sde_out_if;
  logic                       valid;
  logic                       ready;
  logic [sde_pkg::OUT_W-1:0]  word;
  logic                       last;
  logic [1:0]                 status;

  modport source (output valid, output word, output last, output status, input ready);
  modport sink (input valid, input word, input last, input status, output ready);
endinterface

`default_nettype wire

// File: src/sde_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sde_front #(
  parameter int MIN_DELAY = 8,
  parameter int WORD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [sde_pkg::NEURON_W-1:0]  in_neuron_index,
  input  wire logic [sde_pkg::SLICE_W-1:0]   in_slice_index,
  input  wire logic [sde_pkg::GSIZE_W-1:0]   in_group_size,
  input  wire logic [31:0]                   in_attribute_word,
  input  wire logic                          q_full,
  output logic                               push,
  output sde_pkg::cmd_t                      push_cmd
);

  localparam logic [sde_pkg::DELTA_W-1:0] ESC_VALUE =
    (sde_pkg::DELTA_W'(1) << WORD_BITS) - sde_pkg::DELTA_W'(2);
  localparam logic [sde_pkg::DELTA_W-1:0] DELTA_MAX =
    ESC_VALUE * sde_pkg::DELTA_W'(sde_pkg::MAX_WORDS) - sde_pkg::DELTA_W'(1);
  localparam logic [31:0] WORD_MASK = 32'((64'd1 << WORD_BITS) - 64'd1);
  localparam logic [6:0]  MIN_DELAY_V = 7'(MIN_DELAY);
  localparam logic [sde_pkg::DELTA_W-1:0] CARRY_MAX =
    {1'b0, {sde_pkg::CARRY_W{1'b1}}};

  // Stage one: position, span and range checks, independent of state.
  logic                           v1_r;
  logic [1:0]                     op1_r;
  logic [sde_pkg::POS_W:0]        pos1_r;
  logic                           bad1_r;
  logic [31:0]                    span1_r;
  logic [31:0]                    attr1_r;

  logic [sde_pkg::POS_W:0]        pos_calc;
  logic                           bad_calc;
  logic [31:0]                    span_calc;

  // Encoder state.
  logic [sde_pkg::POS_W-1:0]      last_r, last_nxt;
  logic [sde_pkg::CARRY_W-1:0]    carry_r, carry_nxt;

  logic                           adv;
  logic [sde_pkg::DELTA_W-1:0]    delta_raw;
  logic [31:0]                    add_span;
  logic [sde_pkg::DELTA_W-1:0]    carry_sum;

  assign pos_calc = (sde_pkg::POS_W+1)'(in_neuron_index)
                  + (sde_pkg::POS_W+1)'(in_group_size) * (sde_pkg::POS_W+1)'(in_slice_index);
  assign span_calc = 32'(in_group_size) * 32'(MIN_DELAY);
  assign bad_calc = ({1'b0, in_neuron_index} >= in_group_size)
                  || ({4'b0, in_slice_index} >= MIN_DELAY_V)
                  || pos_calc[sde_pkg::POS_W];

  assign adv      = v1_r && !q_full;
  assign in_ready = !v1_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      op1_r   <= in_operation;
      pos1_r  <= pos_calc;
      bad1_r  <= bad_calc;
      span1_r <= span_calc;
      attr1_r <= in_attribute_word & WORD_MASK;
    end
  end

  // Stage two: state update and command build.
  assign delta_raw = sde_pkg::DELTA_W'(pos1_r) + sde_pkg::DELTA_W'(carry_r)
                   - sde_pkg::DELTA_W'(last_r);
  assign add_span  = (span1_r > 32'(last_r)) ? span1_r - 32'(last_r) : 32'd0;
  assign carry_sum = sde_pkg::DELTA_W'(carry_r) + sde_pkg::DELTA_W'(add_span);

  always_comb begin
    logic [sde_pkg::DELTA_W-1:0] dval;
    dval      = '0;
    push      = 1'b0;
    push_cmd  = '0;
    last_nxt  = last_r;
    carry_nxt = carry_r;
    case (op1_r)
      sde_pkg::OP_SPIKE: begin
        push = adv;
        if (bad1_r || (pos1_r < {1'b0, last_r})) begin
          push_cmd.status = sde_pkg::STAT_ORDER;
        end else begin
          push_cmd.is_delta = 1'b1;
          if (delta_raw > DELTA_MAX) begin
            push_cmd.value  = DELTA_MAX;
            push_cmd.status = sde_pkg::STAT_OVERFLOW;
          end else begin
            push_cmd.value  = delta_raw;
          end
          last_nxt  = pos1_r[sde_pkg::POS_W-1:0];
          carry_nxt = '0;
        end
      end
      sde_pkg::OP_ATTRIBUTE: begin
        push           = adv;
        push_cmd.value = sde_pkg::DELTA_W'(attr1_r);
      end
      sde_pkg::OP_GROUP_END: begin
        last_nxt = '0;
        if (carry_sum > CARRY_MAX) begin
          push            = adv;
          push_cmd.status = sde_pkg::STAT_OVERFLOW;
          carry_nxt       = {sde_pkg::CARRY_W{1'b1}};
        end else begin
          carry_nxt       = carry_sum[sde_pkg::CARRY_W-1:0];
        end
      end
      default: begin
        // Terminate: the carry goes out as one last delta.
        push              = adv;
        push_cmd.is_delta = 1'b1;
        dval              = sde_pkg::DELTA_W'(carry_r);
        if (dval > DELTA_MAX) begin
          push_cmd.value  = DELTA_MAX;
          push_cmd.status = sde_pkg::STAT_OVERFLOW;
        end else begin
          push_cmd.value  = dval;
        end
        last_nxt  = '0;
        carry_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      carry_r <= '0;
    end else if (adv) begin
      last_r  <= last_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/sde_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sde_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sde_pkg::cmd_t  push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output sde_pkg::cmd_t       q_cmd
);

  sde_pkg::cmd_t                      entry_r [sde_pkg::QUEUE_DEPTH];
  logic [sde_pkg::QUEUE_IDX_W-1:0]    wr_ptr_r;
  logic [sde_pkg::QUEUE_IDX_W-1:0]    rd_ptr_r;
  logic [sde_pkg::QUEUE_CNT_W-1:0]    count_r;

  assign full    = (count_r == sde_pkg::QUEUE_CNT_W'(sde_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: src/sde_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sde_back #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  wire sde_pkg::cmd_t              q_cmd,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [sde_pkg::OUT_W-1:0]       out_word,
  output logic                            out_last,
  output logic [1:0]                      out_status
);

  localparam logic [sde_pkg::DELTA_W-1:0] ESC_VALUE =
    (sde_pkg::DELTA_W'(1) << WORD_BITS) - sde_pkg::DELTA_W'(2);

  sde_pkg::cmd_t  cur_r;
  logic           cur_v_r;
  logic           esc;
  logic           fire;

  // A delta at or above the escape value sends one escape word per cycle while the output is ready.
  assign esc        = cur_r.is_delta && (cur_r.value >= ESC_VALUE);
  assign out_valid  = cur_v_r;
  assign out_word   = esc ? ESC_VALUE[sde_pkg::OUT_W-1:0] : cur_r.value[sde_pkg::OUT_W-1:0];
  assign out_last   = !esc;
  assign out_status = cur_r.status;
  assign fire       = out_valid && out_ready;
  assign pop        = q_valid && (!cur_v_r || (fire && !esc));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
    end else if (pop) begin
      cur_v_r <= 1'b1;
    end else if (fire && !esc) begin
      cur_v_r <= 1'b0;
    end
    if (pop) begin
      cur_r <= q_cmd;
    end else if (fire && esc) begin
      cur_r.value <= cur_r.value - ESC_VALUE;
    end
  end

endmodule

`default_nettype wire

// File: src/spike_delta_encoder.sv
// Spike delta encoder. Each request is a spike, an attribute word, a group end
// or a terminate. A spike at neuron n in delay slice s sits at position
// n + group_size*s in its group, and the block emits the distance from the last
// position plus any carry as a stream word; a distance of 2^WORD_BITS-2 or more
// is first split into escape words of that value, so one spike can give up to
// 33 words. Attribute words pass through masked to WORD_BITS. A group end adds
// the group's unused span to the carry and gives a result only when the carry
// saturates (status 2). A terminate emits the carry and clears the state. A spike
// that is out of range or goes backwards gives a single zero word with status 1
// and leaves the state alone. The last output word of every request has last set.
// Timing: a request is taken every cycle while the four-entry command queue has
// room. The front spends two register stages per request (position, then state
// update); the back sends one word per cycle while the receiver is ready, and the
// back's single output port sets the sustained rate. The first word passes
// through the stage-one register, the command queue and the back's output
// register before it is presented.
`timescale 1ns / 1ps
`default_nettype none

module spike_delta_encoder #(
  parameter int MIN_DELAY = 8,
  parameter int WORD_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sde_in_if.sink      in_chan,
  sde_out_if.source   out_chan
);

  // Escape word value, used by the checks below.
  localparam logic [sde_pkg::OUT_W-1:0] ESC_WORD =
    sde_pkg::OUT_W'((64'd1 << WORD_BITS) - 64'd2);

  logic           q_full;
  logic           push;
  sde_pkg::cmd_t  push_cmd;
  logic           pop;
  logic           q_valid;
  sde_pkg::cmd_t  q_cmd;

  // The front computes positions and keeps the last position and the carry;
  // it turns each request into at most one command.
  sde_front #(
    .MIN_DELAY (MIN_DELAY),
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_ready          (in_chan.ready),
    .in_operation      (in_chan.operation),
    .in_neuron_index   (in_chan.neuron_index),
    .in_slice_index    (in_chan.slice_index),
    .in_group_size     (in_chan.group_size),
    .in_attribute_word (in_chan.attribute_word),
    .q_full            (q_full),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  // The queue lets the front keep taking requests while the back works
  // through a long escape run or waits on the output.
  sde_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // The back holds the current command in its output register and expands a
  // delta into escape words and a final word.
  sde_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (pop),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_word   (out_chan.word),
    .out_last   (out_chan.last),
    .out_status (out_chan.status)
  );

  // The front never writes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
    else $error("command pushed into a full queue");

  // An escape run is never cut short: after a word that is not the last one,
  // another word of the same request follows.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !out_chan.last) |=> out_chan.valid)
    else $error("escape run ended without a final word");

  // A word that is not the last one is always an escape word of a delta.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.last) |->
      (out_chan.word == ESC_WORD && out_chan.status != sde_pkg::STAT_ORDER))
    else $error("non-final word is not an escape word");

endmodule

`default_nettype wire
